FILE: rtl/core/ssrg_pkg.sv
// Shared types, widths and constants of the stepper step rate generator.
package ssrg_pkg;

	localparam int TICK_W = 24;
	localparam int RATE_W = 24;
	localparam int OP_W   = 3;
	localparam int DEN_W  = 9;
	localparam int NUM_W  = 19;
	localparam int PROD_W = TICK_W + DEN_W;
	localparam int DIVR_W = NUM_W + 1;

	localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
	localparam logic [OP_W-1:0] OP_START_RATE = 3'd1;
	localparam logic [OP_W-1:0] OP_START_FLOW = 3'd2;
	localparam logic [OP_W-1:0] OP_STOP       = 3'd3;
	localparam logic [OP_W-1:0] OP_SET_DIR    = 3'd4;

	localparam logic [TICK_W-1:0] TICK_RATE_RESET = 24'd1000000;
	// Count for a 2 Hz toggle rate at the reset tick rate, before clamping.
	localparam longint unsigned RESET_COUNT = (64'd1000000 + 64'd1) / 64'd2;

	// Denominators: Hz in Q16.8, flow in Q16.8 microlitres per minute, and the clamps.
	localparam logic [DEN_W-1:0] DEN_RATE = 9'd256;
	localparam logic [DEN_W-1:0] DEN_FLOW = 9'd63;
	localparam logic [DEN_W-1:0] DEN_MIN  = 9'd20;
	localparam logic [DEN_W-1:0] DEN_MAX  = 9'd1;
	localparam logic [NUM_W-1:0] NUM_MIN  = 19'd1;
	localparam logic [NUM_W-1:0] NUM_MAX  = 19'd2000;

	// Below these the step rate is under 0.05 Hz; above these it is over 2000 Hz.
	localparam logic signed [RATE_W-1:0] LOW_RATE  = 24'sd13;
	localparam logic signed [RATE_W-1:0] LOW_FLOW  = 24'sd4;
	localparam logic signed [RATE_W-1:0] HIGH_RATE = 24'sd512000;
	localparam logic signed [RATE_W-1:0] HIGH_FLOW = 24'sd126000;

	typedef struct packed {
		logic                     flow;
		logic signed [RATE_W-1:0] rate;
		logic [TICK_W-1:0]        tick_rate;
	} rate_req_t;

endpackage

FILE: rtl/core/ssrg_mul.sv
// Bit-serial multiplier: tick rate times denominator, one denominator bit per cycle.
module ssrg_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ssrg_pkg::TICK_W-1:0]  a,
	input  logic [ssrg_pkg::DEN_W-1:0]   b,
	output logic                         done,
	output logic [ssrg_pkg::PROD_W-1:0]  product
);
	import ssrg_pkg::*;

	localparam int CntW = $clog2(DEN_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [TICK_W-1:0] a_q;
	logic [DEN_W-1:0]  b_q;
	logic [PROD_W-1:0] acc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			a_q    <= '0;
			b_q    <= '0;
			acc_q  <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CntW'(DEN_W);
				a_q    <= a;
				b_q    <= b;
				acc_q  <= '0;
			end else if (busy_q) begin
				// Most significant multiplier bit first: double and add.
				acc_q <= {acc_q[PROD_W-2:0], 1'b0} + (b_q[DEN_W-1] ? PROD_W'(a_q) : '0);
				b_q   <= {b_q[DEN_W-2:0], 1'b0};
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done    = done_q;
	assign product = acc_q;

endmodule

FILE: rtl/core/ssrg_div.sv
// Restoring divider producing one quotient bit per cycle.
module ssrg_div (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [ssrg_pkg::PROD_W-1:0]  dividend,
	input  logic [ssrg_pkg::DIVR_W-1:0]  divisor,
	output logic                         done,
	output logic [ssrg_pkg::PROD_W-1:0]  quotient
);
	import ssrg_pkg::*;

	localparam int CntW = $clog2(PROD_W + 1);

	logic              busy_q;
	logic              done_q;
	logic [CntW-1:0]   cnt_q;
	logic [DIVR_W-1:0] divisor_q;
	logic [DIVR_W-1:0] rem_q;
	logic [PROD_W-1:0] quo_q;
	logic [DIVR_W:0]   trial;
	logic [DIVR_W:0]   diff;
	logic              fits;

	// The dividend shifts out of the top of quo_q as quotient bits enter at the bottom.
	assign trial = {rem_q, quo_q[PROD_W-1]};
	assign diff  = trial - {1'b0, divisor_q};
	assign fits  = trial >= {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q    <= 1'b0;
			done_q    <= 1'b0;
			cnt_q     <= '0;
			divisor_q <= '0;
			rem_q     <= '0;
			quo_q     <= '0;
		end else begin
			done_q <= busy_q && (cnt_q == CntW'(1));
			if (start) begin
				busy_q    <= 1'b1;
				cnt_q     <= CntW'(PROD_W);
				divisor_q <= divisor;
				rem_q     <= '0;
				quo_q     <= dividend;
			end else if (busy_q) begin
				rem_q <= fits ? diff[DIVR_W-1:0] : trial[DIVR_W-1:0];
				quo_q <= {quo_q[PROD_W-2:0], fits};
				cnt_q <= cnt_q - CntW'(1);
				if (cnt_q == CntW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: rtl/core/ssrg_reload.sv
// Sequencer turning a step rate or a flow into a timer reload value.
module ssrg_reload #(
	parameter int TIMER_BITS = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  ssrg_pkg::rate_req_t     req,
	output logic                    done,
	output logic [TIMER_BITS-1:0]   reload
);
	import ssrg_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_MUL  = 2'd1;
	localparam logic [1:0] ST_DIV  = 2'd2;

	localparam logic [PROD_W-1:0] MaxCount = PROD_W'((64'd1 << TIMER_BITS) - 64'd1);
	localparam logic [PROD_W-1:0] TwoCount = PROD_W'(2);

	logic [1:0]            state_q;
	logic [NUM_W-1:0]      num_q;
	logic                  tzero_q;
	logic                  done_q;
	logic [TIMER_BITS-1:0] reload_q;

	logic signed [RATE_W-1:0] low_lim;
	logic signed [RATE_W-1:0] high_lim;
	logic [DEN_W-1:0]         den_in;
	logic [NUM_W-1:0]         num_c;
	logic [DEN_W-1:0]         den_c;

	logic              mul_done;
	logic [PROD_W-1:0] mul_prod;
	logic              div_start;
	logic              div_done;
	logic [PROD_W-1:0] div_quo;
	logic              too_fast;

	function automatic logic [TIMER_BITS-1:0] count_to_reload(input logic [PROD_W-1:0] cnt);
		logic [TIMER_BITS-1:0] c;
		if (|cnt[PROD_W-1:TIMER_BITS]) begin
			c = '1;
		end else if (cnt == '0) begin
			c = TIMER_BITS'(1);
		end else begin
			c = cnt[TIMER_BITS-1:0];
		end
		return '0 - c;
	endfunction

	// Clamp the rate to 0.05 .. 2000 Hz as a fraction num/den.
	always_comb begin
		low_lim  = req.flow ? LOW_FLOW : LOW_RATE;
		high_lim = req.flow ? HIGH_FLOW : HIGH_RATE;
		den_in   = req.flow ? DEN_FLOW : DEN_RATE;
		if (req.rate < low_lim) begin
			num_c = NUM_MIN;
			den_c = DEN_MIN;
		end else if (req.rate > high_lim) begin
			num_c = NUM_MAX;
			den_c = DEN_MAX;
		end else begin
			num_c = req.rate[NUM_W-1:0];
			den_c = den_in;
		end
	end

	ssrg_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.a       (req.tick_rate),
		.b       (den_c),
		.done    (mul_done),
		.product (mul_prod)
	);

	// A toggle rate above half the tick rate gives a count of two.
	assign too_fast  = PROD_W'({num_q, 2'b00}) > mul_prod;
	assign div_start = (state_q == ST_MUL) && mul_done && !tzero_q && !too_fast;

	ssrg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (mul_prod + PROD_W'(num_q)),
		.divisor  ({num_q, 1'b0}),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			num_q    <= '0;
			tzero_q  <= 1'b0;
			done_q   <= 1'b0;
			reload_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						num_q   <= num_c;
						tzero_q <= req.tick_rate == '0;
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (mul_done) begin
						if (tzero_q) begin
							reload_q <= count_to_reload(MaxCount);
							done_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else if (too_fast) begin
							reload_q <= count_to_reload(TwoCount);
							done_q   <= 1'b1;
							state_q  <= ST_IDLE;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						reload_q <= count_to_reload(div_quo);
						done_q   <= 1'b1;
						state_q  <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign done   = done_q;
	assign reload = reload_q;

endmodule

FILE: rtl/core/stepper_step_rate_generator.sv
// Top level of the stepper step rate generator: command decode, pin state and result register.
//
//   Channel   Direction  Payload
//   s_axis    in         tdata: rate_value[23:0], forward[24]; tuser: opcode[2:0]
//   m_axis    out        tdata: step_pin, direction_pin, is_running, reload_value
//   cfg       in         cfg_wr_data: tick_rate_hz
//
// Tick, stop, set-direction and unused opcodes complete at once and can follow back to back
// while m_axis takes each result. A start returns its result through the 9-step serial
// multiplier and the 33-step serial divider; a zero tick rate or a toggle rate above
// half the tick rate skips the divider.
// Reset stops the generator, sets direction forward and the reload to the clamped 2 Hz count.
// A stall on m_axis holds the result and holds off s_axis.
module stepper_step_rate_generator #(
	parameter int TIMER_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [31:0]                       s_axis_tdata,   // rate_value, forward
	input  logic [ssrg_pkg::OP_W-1:0]         s_axis_tuser,   // opcode
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [((TIMER_BITS+10)/8)*8-1:0]  m_axis_tdata,   // step_pin, direction_pin,
	                                                          // is_running, reload_value
	input  logic                              cfg_wr_en,
	input  logic [ssrg_pkg::TICK_W-1:0]       cfg_wr_data
);
	import ssrg_pkg::*;

	localparam int OUT_W = ((TIMER_BITS + 10) / 8) * 8;
	localparam longint unsigned TimerMax = (64'd1 << TIMER_BITS) - 64'd1;
	localparam longint unsigned RstCount = (RESET_COUNT > TimerMax) ? TimerMax : RESET_COUNT;
	localparam logic [TIMER_BITS-1:0] RstReload = TIMER_BITS'((64'd1 << TIMER_BITS) - RstCount);

	logic                  busy_q;
	logic                  out_valid_q;
	logic [OUT_W-1:0]      out_data_q;
	logic [TIMER_BITS-1:0] counter_q;
	logic [TIMER_BITS-1:0] reload_q;
	logic                  running_q;
	logic                  step_q;
	logic                  dir_q;
	logic [TICK_W-1:0]     tick_rate_q;

	logic [OP_W-1:0]       opcode;
	logic                  accept;
	logic                  is_start;
	logic [TIMER_BITS-1:0] counter_n;
	logic                  running_n;
	logic                  step_n;
	logic                  dir_n;
	rate_req_t             req;
	logic                  rl_done;
	logic [TIMER_BITS-1:0] rl_reload;

	assign opcode        = s_axis_tuser;
	assign s_axis_tready = !busy_q && (!out_valid_q || m_axis_tready);
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign is_start      = (opcode == OP_START_RATE) || (opcode == OP_START_FLOW);

	assign req.flow      = opcode == OP_START_FLOW;
	assign req.rate      = s_axis_tdata[RATE_W-1:0];
	assign req.tick_rate = tick_rate_q;

	// Next state for the commands that complete at once.
	always_comb begin
		counter_n = counter_q;
		running_n = running_q;
		step_n    = step_q;
		dir_n     = dir_q;
		unique case (opcode) inside
			OP_TICK: begin
				if (counter_q == '1) begin
					counter_n = reload_q;
					step_n    = running_q ? !step_q : 1'b0;
				end else begin
					counter_n = counter_q + TIMER_BITS'(1);
				end
			end
			OP_STOP: begin
				running_n = 1'b0;
				step_n    = 1'b0;
			end
			OP_SET_DIR: begin
				dir_n = s_axis_tdata[RATE_W];
			end
			default: begin
			end
		endcase
	end

	ssrg_reload #(
		.TIMER_BITS (TIMER_BITS)
	) u_reload (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (accept && is_start),
		.req    (req),
		.done   (rl_done),
		.reload (rl_reload)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			out_data_q  <= '0;
			counter_q   <= RstReload;
			reload_q    <= RstReload;
			running_q   <= 1'b0;
			step_q      <= 1'b0;
			dir_q       <= 1'b1;
			tick_rate_q <= TICK_RATE_RESET;
		end else begin
			if (cfg_wr_en) begin
				tick_rate_q <= cfg_wr_data;
			end
			if (rl_done) begin
				busy_q      <= 1'b0;
				reload_q    <= rl_reload;
				counter_q   <= rl_reload;
				running_q   <= 1'b1;
				step_q      <= 1'b0;
				out_valid_q <= 1'b1;
				out_data_q  <= OUT_W'({rl_reload, 1'b1, dir_q, 1'b0});
			end else if (accept && is_start) begin
				busy_q <= 1'b1;
				if (m_axis_tready) begin
					out_valid_q <= 1'b0;
				end
			end else if (accept) begin
				counter_q   <= counter_n;
				running_q   <= running_n;
				step_q      <= step_n;
				dir_q       <= dir_n;
				out_valid_q <= 1'b1;
				out_data_q  <= OUT_W'({reload_q, running_n, dir_n, step_n});
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

endmodule
